// ----- src/svt_pkg.sv -----
// shared types and codes for the sorted value table
// no dependencies; used by svt_ctrl, svt_datapath and sorted_value_table_core
package svt_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_MISS  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic  load;
    logic  exec;
    kind_t kind;
    logic  rotate;
    logic  emit;
    logic  last;
  } svt_cmd_t;

endpackage

// ----- src/svt_ctrl.sv -----
// controller for the sorted value table: sequences compare, apply and dump rotation
// depends on svt_pkg; drives svt_datapath through svt_pkg::svt_cmd_t
module svt_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [1:0]                     kind,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  output logic                           busy,
  output svt_pkg::svt_cmd_t              cmd
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int RotW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_ROT  = 3'b100
  } state_t;

  state_t          state, state_next;
  svt_pkg::kind_t  kind_reg;
  logic [RotW-1:0] rot_cnt, rot_cnt_next;
  logic [CntW:0]   rot_sum;
  logic            accept;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign rot_sum = (CntW+1)'(rot_cnt) + (CntW+1)'(count);

  always_comb begin
    state_next   = state;
    rot_cnt_next = rot_cnt;
    cmd          = '0;
    cmd.kind     = kind_reg;
    cmd.load     = accept;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (kind_reg == svt_pkg::KIND_DUMP && count != '0) begin
          state_next   = ST_ROT;
          rot_cnt_next = '0;
        end else begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ROT: begin
        cmd.rotate = 1'b1;
        cmd.emit   = (rot_sum >= (CntW+1)'(DEPTH));
        cmd.last   = (rot_cnt == RotW'(DEPTH - 1));
        if (cmd.last) begin
          state_next = ST_IDLE;
        end else begin
          rot_cnt_next = rot_cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rot_cnt <= '0;
    end else begin
      state   <= state_next;
      rot_cnt <= rot_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_reg <= svt_pkg::kind_t'(kind);
    end
  end

endmodule

// ----- src/svt_datapath.sv -----
// datapath for the sorted value table: a row of compare-and-shift cells, count and result register
// depends on svt_pkg; commanded by svt_ctrl
module svt_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  svt_pkg::svt_cmd_t                    cmd,
  input  logic signed [svt_pkg::VALUE_W-1:0]   key_value,
  output logic [$clog2(DEPTH+1)-1:0]           count,
  output logic                                 strobe,
  output logic [1:0]                           status,
  output logic signed [svt_pkg::VALUE_W-1:0]   out_value,
  output logic [svt_pkg::COUNT_W-1:0]          entry_count,
  output logic                                 last
);

  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int ValW   = svt_pkg::VALUE_W;
  localparam int CntOutW = svt_pkg::COUNT_W;

  logic signed [ValW-1:0] slot      [DEPTH];
  logic signed [ValW-1:0] slot_next [DEPTH];
  logic signed [ValW-1:0] key_reg;
  logic [DEPTH-1:0]       lt, eq;
  logic [CntW-1:0]        count_next;
  logic                   found, full;
  logic                   do_insert, do_remove;
  svt_pkg::status_t       status_next;
  logic signed [ValW-1:0] value_next;

  assign found = |eq;
  assign full  = (count == CntW'(DEPTH));

  // per-cell compare against the incoming word
  for (genvar j = 0; j < DEPTH; j++) begin : g_cmp
    always_ff @(posedge clk) begin
      if (cmd.load) begin
        lt[j] <= (count > CntW'(j)) && (slot[j] < key_value);
        eq[j] <= (count > CntW'(j)) && (slot[j] == key_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_reg <= key_value;
    end
  end

  always_comb begin
    do_insert = cmd.exec && cmd.kind == svt_pkg::KIND_INSERT && !full;
    do_remove = cmd.exec && cmd.kind == svt_pkg::KIND_REMOVE && found;
  end

  // shift network, each cell sees only its neighbours
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    always_comb begin
      slot_next[j] = slot[j];
      if (cmd.rotate) begin
        slot_next[j] = (j == 0) ? slot[DEPTH-1] : slot[(j == 0) ? 0 : j-1];
      end else if (do_insert && !lt[j]) begin
        if (j == 0) begin
          slot_next[j] = key_reg;
        end else if (lt[(j == 0) ? 0 : j-1]) begin
          slot_next[j] = key_reg;
        end else begin
          slot_next[j] = slot[(j == 0) ? 0 : j-1];
        end
      end else if (do_remove && !lt[j] && j < DEPTH-1) begin
        slot_next[j] = slot[(j < DEPTH-1) ? j+1 : j];
      end
    end

    always_ff @(posedge clk) begin
      slot[j] <= slot_next[j];
    end
  end

  always_comb begin
    count_next  = count;
    status_next = svt_pkg::STATUS_OK;
    value_next  = '0;
    if (cmd.exec) begin
      case (cmd.kind)
        svt_pkg::KIND_INSERT: begin
          if (full) begin
            status_next = svt_pkg::STATUS_FULL;
          end else begin
            count_next = count + 1'b1;
          end
        end
        svt_pkg::KIND_REMOVE: begin
          if (found) begin
            count_next = count - 1'b1;
            value_next = key_reg;
          end else begin
            status_next = svt_pkg::STATUS_MISS;
          end
        end
        svt_pkg::KIND_SEARCH: begin
          if (found) begin
            value_next = key_reg;
          end else begin
            status_next = svt_pkg::STATUS_MISS;
          end
        end
        default: begin
          status_next = svt_pkg::STATUS_EMPTY;
        end
      endcase
    end else if (cmd.emit) begin
      value_next = slot[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      count  <= count_next;
      strobe <= cmd.exec || cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.emit) begin
      status      <= status_next;
      out_value   <= value_next;
      entry_count <= CntOutW'(count_next);
      last        <= cmd.exec || cmd.last;
    end
  end

endmodule

// ----- src/sorted_value_table_core.sv -----
// sorted value table: ascending store of signed words with insert, remove, search and dump
// depends on svt_pkg, svt_ctrl and svt_datapath
//
// usage
//   a command word (kind, key_value) is taken at a rising edge with start high and busy low
//   each result word appears for one cycle on status, out_value, entry_count and last,
//   marked by strobe; last is high on the final result of a command
// timing
//   insert, remove, search: the per-cell compares are captured on acceptance; then the
//   compare state shifts the cell row and loads the result and strobe registers
//   dump: the cell row is rotated once round its full DEPTH cells, one position a cycle,
//   and the top cell is emitted once the valid entries reach it, largest first; an empty
//   table gives one result with status EMPTY
//   busy drops in the cycle that the last result is strobed, so a new command may overlap it
// reset
//   rst clears the entry count and the controller; cell contents are undefined until written
// back-pressure
//   none: the receiver must take every result in the cycle it is strobed
module sorted_value_table_core #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [1:0]                          kind,
  input  logic signed [svt_pkg::VALUE_W-1:0]  key_value,
  output logic                                busy,
  output logic                                strobe,
  output logic [1:0]                          status,
  output logic signed [svt_pkg::VALUE_W-1:0]  out_value,
  output logic [svt_pkg::COUNT_W-1:0]         entry_count,
  output logic                                last
);

  svt_pkg::svt_cmd_t             cmd;
  logic [$clog2(DEPTH+1)-1:0]    count;

  svt_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .count (count),
    .busy  (busy),
    .cmd   (cmd)
  );

  svt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .key_value   (key_value),
    .count       (count),
    .strobe      (strobe),
    .status      (status),
    .out_value   (out_value),
    .entry_count (entry_count),
    .last        (last)
  );

endmodule
